### src/interval_value_map_unit_macros.svh
`ifndef INTERVAL_VALUE_MAP_UNIT_MACROS_SVH
`define INTERVAL_VALUE_MAP_UNIT_MACROS_SVH

// same-cycle implication, reset disables
`define IVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval map check failed");

// next-cycle implication, reset disables
`define IVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval map check failed");

`endif

### src/ivm_pkg.sv
package ivm_pkg;

    localparam int MAX_BOUNDARIES = 64;
    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 8;
    localparam int CNT_W          = $clog2(MAX_BOUNDARIES + 1);

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DEFAULT  = 1'b0;

    localparam logic FUNC_ASSIGN  = 1'b0;
    localparam logic FUNC_LOOKUP  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_SHL,
        CELL_INS
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [KEY_BITS-1:0]    key_a;
        logic [KEY_BITS-1:0]    key_b;
        logic [KEY_BITS-1:0]    ins_key;
        logic [VALUE_BITS-1:0]  ins_value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                   valid;
        logic                   ge;
        logic                   le;
        logic                   del;
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
    } cell_state_t;

    typedef struct packed {
        logic                   a_hit;
        logic [VALUE_BITS-1:0]  a_val;
        logic                   b_hit;
        logic [VALUE_BITS-1:0]  b_val;
        logic                   any_del;
        logic                   two_del;
    } sel_t;

endpackage

### src/interval_value_map_unit.sv
// a lookup, an empty range or a rejected assign gives its word after S_CMP and S_SEL;
// an assign that is carried out then passes through S_DEL once for each boundary it
// removes (one per cycle through the cell row), then S_INS_E and S_INS_S for the ones it adds
// busy is low again in the cycle that shows the result, so a new item can be started in that cycle
// reset empties the table and sets the default value to zero; no clearing pass
module interval_value_map_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ivm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ivm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ivm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                start,
    input  logic                                func,
    input  logic [ivm_pkg::KEY_BITS-1:0]        range_start,
    input  logic [ivm_pkg::KEY_BITS-1:0]        range_end,
    input  logic [ivm_pkg::VALUE_BITS-1:0]      fill_value,
    output logic                                busy,
    output logic                                done,
    output logic [ivm_pkg::VALUE_BITS-1:0]      found_value,
    output logic [1:0]                          status,
    output logic [ivm_pkg::CNT_W-1:0]           boundary_count
);

    localparam int N  = ivm_pkg::MAX_BOUNDARIES;
    localparam int CW = ivm_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_DEL,
        S_INS_E,
        S_INS_S
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           func_reg;
    logic                           func_next;
    logic [ivm_pkg::KEY_BITS-1:0]   start_key_reg;
    logic [ivm_pkg::KEY_BITS-1:0]   start_key_next;
    logic [ivm_pkg::KEY_BITS-1:0]   end_key_reg;
    logic [ivm_pkg::KEY_BITS-1:0]   end_key_next;
    logic [ivm_pkg::VALUE_BITS-1:0] fill_reg;
    logic [ivm_pkg::VALUE_BITS-1:0] fill_next;
    logic [ivm_pkg::VALUE_BITS-1:0] end_val_reg;
    logic [ivm_pkg::VALUE_BITS-1:0] end_val_next;
    logic                           add_s_reg;
    logic                           add_s_next;
    logic                           add_e_reg;
    logic                           add_e_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [ivm_pkg::VALUE_BITS-1:0] default_reg;
    logic [ivm_pkg::VALUE_BITS-1:0] default_next;
    logic                           done_reg;
    logic                           done_next;
    logic [ivm_pkg::VALUE_BITS-1:0] found_reg;
    logic [ivm_pkg::VALUE_BITS-1:0] found_next;
    logic [1:0]                     status_reg;
    logic [1:0]                     status_next;

    ivm_pkg::cell_ctrl_t            ctrl;
    ivm_pkg::cell_state_t           cells [N];
    ivm_pkg::sel_t                  sel;

    logic [ivm_pkg::VALUE_BITS-1:0] prev_val;
    logic [ivm_pkg::VALUE_BITS-1:0] old_e_val;
    logic                           add_s;
    logic                           add_e;
    logic [1:0]                     del_cap;
    logic [CW:0]                    need_cnt;
    logic [CW:0]                    room_cnt;
    logic                           cfg_write;

    for (genvar g = 0; g < N; g++)
    begin : g_row
        ivm_pkg::cell_state_t left_st;
        ivm_pkg::cell_state_t right_st;
        if (g == 0)
        begin : g_first
            assign left_st = '0;
        end
        else
        begin : g_mid_l
            assign left_st = cells[g-1];
        end
        if (g == N - 1)
        begin : g_last
            assign right_st = '0;
        end
        else
        begin : g_mid_r
            assign right_st = cells[g+1];
        end
        ivm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .left     (left_st),
            .right    (right_st),
            .cell_out (cells[g])
        );
    end

    ivm_select u_select (
        .cells (cells),
        .sel   (sel)
    );

    assign prev_val  = sel.a_hit ? sel.a_val : default_reg;
    assign old_e_val = sel.b_hit ? sel.b_val : default_reg;
    assign add_s     = (prev_val != fill_reg);
    assign add_e     = (old_e_val != fill_reg);
    assign del_cap   = sel.two_del ? 2'd2 : (sel.any_del ? 2'd1 : 2'd0);
    assign need_cnt  = (CW+1)'(count_reg) + (CW+1)'(add_s) + (CW+1)'(add_e);
    assign room_cnt  = (CW+1)'(N) + (CW+1)'(del_cap);

    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        ctrl.op        = ivm_pkg::CELL_HOLD;
        ctrl.key_a     = start_key_reg;
        ctrl.key_b     = (func_reg == ivm_pkg::FUNC_LOOKUP) ? start_key_reg : end_key_reg;
        ctrl.ins_key   = start_key_reg;
        ctrl.ins_value = fill_reg;
        case (state_reg)
            S_CMP:   ctrl.op = ivm_pkg::CELL_CMP;
            S_DEL:   ctrl.op = ivm_pkg::CELL_SHL;
            S_INS_E:
            begin
                ctrl.op        = ivm_pkg::CELL_INS;
                ctrl.ins_key   = end_key_reg;
                ctrl.ins_value = end_val_reg;
            end
            S_INS_S: ctrl.op = ivm_pkg::CELL_INS;
            default: ctrl.op = ivm_pkg::CELL_HOLD;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        start_key_next = start_key_reg;
        end_key_next   = end_key_reg;
        fill_next      = fill_reg;
        end_val_next   = end_val_reg;
        add_s_next     = add_s_reg;
        add_e_next     = add_e_reg;
        count_next     = count_reg;
        default_next   = default_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        status_next    = status_reg;

        if (cfg_write && (paddr[2] == ivm_pkg::REG_DEFAULT))
            default_next = pwdata[ivm_pkg::VALUE_BITS-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = func;
                    start_key_next = range_start;
                    end_key_next   = range_end;
                    fill_next      = fill_value;
                    state_next     = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                add_s_next   = add_s;
                add_e_next   = add_e;
                end_val_next = old_e_val;
                found_next   = '0;
                status_next  = ivm_pkg::ST_DONE;
                if (func_reg == ivm_pkg::FUNC_LOOKUP)
                begin
                    found_next = old_e_val;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!(start_key_reg < end_key_reg))
                begin
                    status_next = ivm_pkg::ST_EMPTY;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (need_cnt > room_cnt)
                begin
                    status_next = ivm_pkg::ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sel.any_del)
                    state_next = S_DEL;
                else if (add_e)
                    state_next = S_INS_E;
                else if (add_s)
                    state_next = S_INS_S;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEL:
            begin
                count_next = count_reg - CW'(1);
                if (!sel.two_del)
                begin
                    if (add_e_reg)
                        state_next = S_INS_E;
                    else if (add_s_reg)
                        state_next = S_INS_S;
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_INS_E:
            begin
                count_next = count_reg + CW'(1);
                if (add_s_reg)
                    state_next = S_INS_S;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS_S:
            begin
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            default_reg <= '0;
            add_s_reg   <= 1'b0;
            add_e_reg   <= 1'b0;
            func_reg    <= ivm_pkg::FUNC_ASSIGN;
            done_reg    <= 1'b0;
            found_reg   <= '0;
            status_reg  <= ivm_pkg::ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            default_reg <= default_next;
            add_s_reg   <= add_s_next;
            add_e_reg   <= add_e_next;
            func_reg    <= func_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_key_reg <= start_key_next;
        end_key_reg   <= end_key_next;
        fill_reg      <= fill_next;
        end_val_reg   <= end_val_next;
    end

    assign prdata = (paddr[2] == ivm_pkg::REG_DEFAULT)
                  ? ivm_pkg::APB_DATA_BITS'(default_reg) : '0;
    assign pready = 1'b1;

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign found_value    = found_reg;
    assign status         = status_reg;
    assign boundary_count = count_reg;

endmodule

### src/ivm_cell.sv
module ivm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ivm_pkg::cell_ctrl_t  ctrl,
    input  ivm_pkg::cell_state_t left,
    input  ivm_pkg::cell_state_t right,
    output ivm_pkg::cell_state_t cell_out
);

    logic                           valid_reg;
    logic                           valid_next;
    logic                           ge_reg;
    logic                           ge_next;
    logic                           le_reg;
    logic                           le_next;
    logic                           del_reg;
    logic                           del_next;
    logic [ivm_pkg::KEY_BITS-1:0]   key_reg;
    logic [ivm_pkg::KEY_BITS-1:0]   key_next;
    logic [ivm_pkg::VALUE_BITS-1:0] value_reg;
    logic [ivm_pkg::VALUE_BITS-1:0] value_next;
    logic                           lt_a;
    logic                           le_b;

    assign lt_a = valid_reg && (key_reg < ctrl.key_a);
    assign le_b = valid_reg && (key_reg <= ctrl.key_b);

    always_comb
    begin
        valid_next = valid_reg;
        ge_next    = ge_reg;
        le_next    = le_reg;
        del_next   = del_reg;
        key_next   = key_reg;
        value_next = value_reg;
        case (ctrl.op)
            ivm_pkg::CELL_CMP:
            begin
                ge_next  = !lt_a;
                le_next  = le_b;
                del_next = valid_reg && !lt_a && le_b;
            end
            // close the gap at the first removed entry
            ivm_pkg::CELL_SHL:
            begin
                if (ge_reg)
                begin
                    valid_next = right.valid;
                    del_next   = right.del;
                    key_next   = right.key;
                    value_next = right.value;
                end
            end
            // open a slot at the range start
            ivm_pkg::CELL_INS:
            begin
                if (ge_reg)
                begin
                    del_next = 1'b0;
                    if (left.ge)
                    begin
                        valid_next = left.valid;
                        key_next   = left.key;
                        value_next = left.value;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        key_next   = ctrl.ins_key;
                        value_next = ctrl.ins_value;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ge_reg    <= 1'b0;
            le_reg    <= 1'b0;
            del_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ge_reg    <= ge_next;
            le_reg    <= le_next;
            del_reg   <= del_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.ge    = ge_reg;
    assign cell_out.le    = le_reg;
    assign cell_out.del   = del_reg;
    assign cell_out.key   = key_reg;
    assign cell_out.value = value_reg;

endmodule

### src/ivm_select.sv
module ivm_select (
    input  ivm_pkg::cell_state_t cells [ivm_pkg::MAX_BOUNDARIES],
    output ivm_pkg::sel_t        sel
);

    localparam int N = ivm_pkg::MAX_BOUNDARIES;

    logic [N-1:0] lt_vec;
    logic [N-1:0] le_vec;
    logic [N-1:0] del_vec;
    logic [N-1:0] lt_last;
    logic [N-1:0] le_last;
    logic [ivm_pkg::VALUE_BITS-1:0] a_val;
    logic [ivm_pkg::VALUE_BITS-1:0] b_val;

    for (genvar g = 0; g < N; g++)
    begin : g_flags
        assign lt_vec[g]  = !cells[g].ge;
        assign le_vec[g]  = cells[g].le;
        assign del_vec[g] = cells[g].del;
    end

    // last entry of each thermometer run
    assign lt_last = lt_vec & ~{1'b0, lt_vec[N-1:1]};
    assign le_last = le_vec & ~{1'b0, le_vec[N-1:1]};

    always_comb
    begin
        a_val = '0;
        b_val = '0;
        for (int i = 0; i < N; i++)
        begin
            if (lt_last[i])
                a_val = a_val | cells[i].value;
            if (le_last[i])
                b_val = b_val | cells[i].value;
        end
    end

    assign sel.a_hit   = lt_vec[0];
    assign sel.a_val   = a_val;
    assign sel.b_hit   = le_vec[0];
    assign sel.b_val   = b_val;
    assign sel.any_del = |del_vec;
    assign sel.two_del = |(del_vec & {1'b0, del_vec[N-1:1]});

endmodule

### src/ivm_checker.sv
`include "interval_value_map_unit_macros.svh"

module ivm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic [ivm_pkg::VALUE_BITS-1:0]   found_value,
    input logic [1:0]                       status,
    input logic [ivm_pkg::CNT_W-1:0]        boundary_count
);

    // a word is shown only once the unit has let go of the item
    `IVM_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    `IVM_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // every item ends with a word when busy falls
    `IVM_ASSERT_IMP(a_end_word, clk, rst_n, $fell(busy), done)

    // ignored or rejected assigns leave the table alone and report no value
    `IVM_ASSERT_IMP(a_no_change, clk, rst_n,
                    done && (status != ivm_pkg::ST_DONE),
                    (found_value == '0) && (boundary_count == $past(boundary_count)))

endmodule

bind interval_value_map_unit ivm_checker u_ivm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .found_value    (found_value),
    .status         (status),
    .boundary_count (boundary_count)
);
